### rtl/stq_pkg.sv
// Shared types and codes for the sorted timer queue.
// Used by stq_ctrl, stq_dpath and sorted_timer_queue; no other dependencies.
`timescale 1ns / 1ps
package stq_pkg;
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_ADJUST = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_EXPIRED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_ABSENT    = 3'd3;
    localparam logic [2:0] ST_DUPLICATE = 3'd4;

    // Commands from the controller to the shift chain.
    typedef struct packed {
        logic load;      // capture the input item
        logic remove;    // take out the entry of the loaded owner
        logic insert;    // place the loaded owner by the loaded expiry
        logic pop;       // take out the head entry
        logic set_pres;  // mark the loaded owner present
        logic clr_pres;  // mark the loaded owner absent
    } stq_cmd_t;

    // Status from the shift chain to the controller.
    typedef struct packed {
        logic       present;  // loaded owner is held
        logic       full;     // no free slot
        logic       head_due; // head entry exists and is due
        logic [5:0] head_id;  // owner of the head entry
    } stq_stat_t;
endpackage

### rtl/stq_dpath.sv
// Sorted shift chain of timer slots with presence bits and the item registers.
// Depends on stq_pkg.
`timescale 1ns / 1ps
module stq_dpath #(
    parameter int CAPACITY = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  stq_pkg::stq_cmd_t cmd,
    input  logic [5:0]        in_id,
    input  logic [31:0]       in_expire,
    input  logic [31:0]       in_now,
    output stq_pkg::stq_stat_t stat,
    output logic [6:0]        count
);
    logic [31:0] exp_reg [CAPACITY];
    logic [5:0]  own_reg [CAPACITY];
    logic [CAPACITY-1:0] vld_reg;
    logic [63:0] pres_reg;
    logic [6:0]  cnt_reg;
    logic [5:0]  id_reg;
    logic [31:0] expire_reg;
    logic [31:0] now_reg;
    logic [CAPACITY-1:0] match, le, gone;

    // Per-slot compares. A slot is gone when the matching entry sits at or
    // below it, so it takes its upper neighbor on a remove.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = vld_reg[i] && (own_reg[i] == id_reg);
            le[i]    = vld_reg[i] && (exp_reg[i] <= expire_reg);
        end
        for (int i = 0; i < CAPACITY; i++)
            gone[i] = |(match & ~({CAPACITY{1'b1}} << (i + 1)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            pres_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (cmd.set_pres)
                pres_reg[id_reg] <= 1'b1;
            else if (cmd.clr_pres)
                pres_reg[id_reg] <= 1'b0;
            else if (cmd.pop)
                pres_reg[own_reg[0]] <= 1'b0;

            if (cmd.pop || cmd.remove) begin
                for (int i = 0; i < CAPACITY - 1; i++)
                    if (cmd.pop || gone[i]) vld_reg[i] <= vld_reg[i+1];
                if (cmd.pop || gone[CAPACITY-1]) vld_reg[CAPACITY-1] <= 1'b0;
                cnt_reg <= cnt_reg - 7'd1;
            end else if (cmd.insert) begin
                // The valid run is contiguous, so it simply grows by one slot.
                vld_reg <= {vld_reg[CAPACITY-2:0], 1'b1};
                cnt_reg <= cnt_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg     <= in_id;
            expire_reg <= in_expire;
            now_reg    <= in_now;
        end
        if (cmd.pop || cmd.remove) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (cmd.pop || gone[i]) begin
                    exp_reg[i] <= exp_reg[i+1];
                    own_reg[i] <= own_reg[i+1];
                end
            end
        end else if (cmd.insert) begin
            // Slots due at or before the new entry keep theirs; the first slot
            // past them takes the new entry; the rest shift up.
            if (!le[0]) begin
                exp_reg[0] <= expire_reg;
                own_reg[0] <= id_reg;
            end
            for (int i = 1; i < CAPACITY; i++) begin
                if (!le[i]) begin
                    if (le[i-1]) begin
                        exp_reg[i] <= expire_reg;
                        own_reg[i] <= id_reg;
                    end else begin
                        exp_reg[i] <= exp_reg[i-1];
                        own_reg[i] <= own_reg[i-1];
                    end
                end
            end
        end
    end

    assign count         = cnt_reg;
    assign stat.present  = pres_reg[id_reg];
    assign stat.full     = vld_reg[CAPACITY-1];
    assign stat.head_due = vld_reg[0] && (exp_reg[0] <= now_reg);
    assign stat.head_id  = own_reg[0];

    // Valid slots always form a contiguous run from slot zero.
    a_contig: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg & (vld_reg + CAPACITY'(1))) == '0)
        else $error("slot chain has a gap");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(vld_reg) == int'(cnt_reg)) else $error("entry count out of step");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> vld_reg[0]) else $error("pop of an empty chain");
    a_ins_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> !vld_reg[CAPACITY-1]) else $error("insert into a full chain");
endmodule

### rtl/stq_ctrl.sv
// Command sequencer of the sorted timer queue and its result register.
// Depends on stq_pkg.
`timescale 1ns / 1ps
module stq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  stq_pkg::stq_stat_t stat,
    input  logic [6:0]         count,
    output stq_pkg::stq_cmd_t  cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [5:0]         m_expired_id,
    output logic               m_last,
    output logic [6:0]         m_occupancy
);
    typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_REINS, S_TICK, S_PEEK, S_WAIT}
        state_t;

    state_t      state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic        mv_reg, mv_next;
    logic [2:0]  st_reg, st_next;
    logic [5:0]  eid_reg, eid_next;
    logic        last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        mv_next    = mv_reg;
        st_next    = st_reg;
        eid_next   = eid_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_ready    = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    op_next    = s_command;
                    state_next = (s_command == stq_pkg::CMD_TICK) ? S_TICK : S_DECIDE;
                end
            end
            S_DECIDE: begin
                last_next  = 1'b1;
                eid_next   = '0;
                st_next    = stq_pkg::ST_DONE;
                mv_next    = 1'b1;
                state_next = S_WAIT;
                case (op_reg)
                    stq_pkg::CMD_ADD: begin
                        if (stat.present) st_next = stq_pkg::ST_DUPLICATE;
                        else if (stat.full) st_next = stq_pkg::ST_FULL;
                        else begin
                            cmd.insert   = 1'b1;
                            cmd.set_pres = 1'b1;
                        end
                    end
                    stq_pkg::CMD_ADJUST: begin
                        if (!stat.present) st_next = stq_pkg::ST_ABSENT;
                        else begin
                            cmd.remove = 1'b1;
                            mv_next    = 1'b0;
                            state_next = S_REINS;
                        end
                    end
                    stq_pkg::CMD_DELETE: begin
                        if (!stat.present) st_next = stq_pkg::ST_ABSENT;
                        else begin
                            cmd.remove   = 1'b1;
                            cmd.clr_pres = 1'b1;
                        end
                    end
                    default: begin
                        mv_next    = 1'b0;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_REINS: begin
                cmd.insert = 1'b1;
                mv_next    = 1'b1;
                state_next = S_WAIT;
            end
            S_TICK: begin
                // One pop per result; the chain settles before the next look.
                if (stat.head_due) begin
                    cmd.pop    = 1'b1;
                    st_next    = stq_pkg::ST_EXPIRED;
                    eid_next   = stat.head_id;
                    state_next = S_PEEK;
                end else begin
                    st_next    = stq_pkg::ST_DONE;
                    eid_next   = '0;
                    last_next  = 1'b1;
                    mv_next    = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_PEEK: begin
                // The new head decides whether this expired item is the last.
                last_next  = !stat.head_due;
                mv_next    = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (m_ready) begin
                    mv_next    = 1'b0;
                    state_next = last_reg ? S_IDLE : S_TICK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
            op_reg    <= stq_pkg::CMD_ADD;
            st_reg    <= stq_pkg::ST_DONE;
            eid_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
            op_reg    <= op_next;
            st_reg    <= st_next;
            eid_reg   <= eid_next;
            last_reg  <= last_next;
        end
    end

    assign m_valid      = mv_reg;
    assign m_status     = st_reg;
    assign m_expired_id = eid_reg;
    assign m_last       = last_reg;
    assign m_occupancy  = count;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mv_reg) else $error("accept while a result waits");
    a_one_mut: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.remove, cmd.insert, cmd.pop}) <= 1)
        else $error("two chain edits at once");
    a_pop_held: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !mv_reg) else $error("pop while result pending");
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && !m_ready |=> mv_reg && $stable({st_reg, eid_reg, last_reg, count}))
        else $error("result changed while stalled");
endmodule

### rtl/sorted_timer_queue.sv
// Top level of the sorted timer queue: sequencer plus sorted slot chain.
// Depends on stq_pkg, stq_ctrl and stq_dpath.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_command s_timer_id s_expire_time s_now_time
//  m_      | out       | m_valid m_ready m_status m_expired_id m_last m_occupancy
//
// Add and delete accept the item, decide and edit the chain, then hand over
// the result; adjust removes, then re-inserts in the shift chain, before the
// hand-over. A tick with nothing due looks at the head and hands over; a tick
// that expires timers repeats, per timer: pop, look at the new head for the
// last flag, hand over the result. Reset (aresetn low, synchronous) empties
// the chain and clears all presence bits at once. Input waits on a stalled result.
`timescale 1ns / 1ps
module sorted_timer_queue #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [5:0]  s_timer_id,
    input  logic [31:0] s_expire_time,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [5:0]  m_expired_id,
    output logic        m_last,
    output logic [6:0]  m_occupancy
);
    stq_pkg::stq_cmd_t  cmd;
    stq_pkg::stq_stat_t stat;
    logic [6:0]         count;

    // The sequencer issues at most one chain edit per cycle, none while a result
    // waits; a popped owner loses its presence bit inside the chain.
    stq_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .stat, .count, .cmd,
        .m_valid, .m_ready, .m_status, .m_expired_id, .m_last, .m_occupancy
    );

    stq_dpath #(.CAPACITY(CAPACITY)) u_dpath (
        .aclk, .aresetn, .cmd, .in_id(s_timer_id),
        .in_expire(s_expire_time), .in_now(s_now_time), .stat, .count
    );
endmodule
